### hw/rtl/sss_pkg.sv
// Shared types, constants and codes for the seek/separation steering block.
// No dependencies; used by every module of the block.
`default_nettype none
package sss_pkg;

   localparam int MAX_NEIGHBOURS = 256;
   localparam int CNT_W          = 9;
   localparam logic [CNT_W-1:0] NB_CAP =
      CNT_W'((MAX_NEIGHBOURS < 511) ? MAX_NEIGHBOURS : 511);

   localparam int CFG_W = 31;

   localparam logic [CFG_W-1:0] RST_MAX_SPEED  = 31'd65536;
   localparam logic [CFG_W-1:0] RST_MAX_STEER  = 31'd32768;
   localparam logic [CFG_W-1:0] RST_MAX_SEP    = 31'd32768;
   localparam logic [CFG_W-1:0] RST_SEP_RADIUS = 31'd327680;

   localparam logic [5:0] DIV_STEPS_SCALE = 6'd31;
   localparam logic [5:0] DIV_STEPS_PUSH  = 6'd34;
   localparam logic [5:0] SQRT_STEPS      = 6'd32;

   typedef enum logic [1:0] {
      CSR_MAX_SPEED  = 2'd0,
      CSR_MAX_STEER  = 2'd1,
      CSR_MAX_SEP    = 2'd2,
      CSR_SEP_RADIUS = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_LOAD      = 1'b0,
      OP_NEIGHBOUR = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ALU_NONE,
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NB_CHK, ST_NB_SQ1, ST_NB_SQ2, ST_NB_CMP,
      ST_NB_DX, ST_NB_DXW, ST_NB_DYW, ST_NB_END,
      ST_EM_SEEK, ST_EM_SEEK_CL, ST_EM_SEEK_DONE,
      ST_EM_SEP, ST_EM_SEP_CL, ST_EM_SEP_DONE,
      ST_EM_VEL, ST_EM_OUT,
      ST_CL0, ST_CL1, ST_CL2, ST_CL3,
      ST_SC0, ST_SCN, ST_SC_SQ0, ST_SC_SQ1, ST_SC_SQ2,
      ST_SC_RT, ST_SC_RTW, ST_SC_DX, ST_SC_DXW, ST_SC_DY, ST_SC_DYW
   } state_type;

   typedef struct packed {
      alu_op_type  op;
      logic [63:0] opa;
      logic [62:0] opb;
      logic [5:0]  steps;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [61:0] prod;
      logic [33:0] quot;
   } alu_rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] max_speed;
      logic [CFG_W-1:0] max_steer_force;
      logic [CFG_W-1:0] max_separation_force;
      logic [CFG_W-1:0] separation_radius;
   } cfg_type;

   typedef struct packed {
      op_type             opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic               final_item;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic [CNT_W-1:0]   close_count;
   } emit_type;

endpackage
`default_nettype wire

### hw/rtl/sss_alu.sv
// Shared arithmetic unit: 31x31 multiplier with a registered product, restoring divider and
// square root, one bit per cycle over a single subtractor. Uses sss_pkg.
`default_nettype none
module sss_alu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sss_pkg::alu_cmd_type cmd,
   output sss_pkg::alu_rsp_type     rsp
);

   sss_pkg::alu_op_type mode_ff, mode_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [62:0] rem_ff, rem_in;
   logic [63:0] num_ff, num_in;
   logic [62:0] den_ff, den_in;
   logic [33:0] q_ff, q_in;
   logic [61:0] prod_ff, prod_in;
   logic        done_ff, done_in;

   logic [63:0] sub_a, sub_b;
   logic [64:0] diff;
   logic        ge;

   always_comb begin
      sub_a = '0;
      sub_b = '0;
      case (mode_ff)
         sss_pkg::ALU_DIV: begin
            sub_a = {rem_ff, num_ff[63]};
            sub_b = {1'b0, den_ff};
         end
         sss_pkg::ALU_SQRT: begin
            sub_a = 64'({rem_ff[33:0], num_ff[63:62]});
            sub_b = 64'({q_ff[31:0], 2'b01});
         end
         default: begin
         end
      endcase
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = ~diff[64];

      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      prod_in = prod_ff;
      done_in = 1'b0;

      case (mode_ff)
         sss_pkg::ALU_DIV: begin
            rem_in = ge ? diff[62:0] : sub_a[62:0];
            q_in   = {q_ff[32:0], ge};
            num_in = {num_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               done_in = 1'b1;
               mode_in = sss_pkg::ALU_NONE;
            end
         end
         sss_pkg::ALU_SQRT: begin
            rem_in = ge ? 63'(diff[35:0]) : 63'(sub_a[35:0]);
            q_in   = {q_ff[32:0], ge};
            num_in = {num_ff[61:0], 2'b00};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               done_in = 1'b1;
               mode_in = sss_pkg::ALU_NONE;
            end
         end
         default: begin
         end
      endcase

      case (cmd.op)
         sss_pkg::ALU_MUL: begin
            prod_in = 62'(cmd.opa[30:0]) * 62'(cmd.opb[30:0]);
         end
         sss_pkg::ALU_DIV: begin
            mode_in = sss_pkg::ALU_DIV;
            rem_in  = 63'(cmd.opa >> cmd.steps);
            num_in  = cmd.opa << (7'd64 - {1'b0, cmd.steps});
            den_in  = cmd.opb;
            q_in    = '0;
            cnt_in  = cmd.steps;
         end
         sss_pkg::ALU_SQRT: begin
            mode_in = sss_pkg::ALU_SQRT;
            rem_in  = '0;
            num_in  = cmd.opa;
            q_in    = '0;
            cnt_in  = sss_pkg::SQRT_STEPS;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sss_pkg::ALU_NONE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = prod_ff;
   assign rsp.quot = q_ff;

endmodule
`default_nettype wire

### hw/rtl/sss_seq.sv
// Sequencer and agent state: neighbour push accumulation, seek, separation
// and speed limiting, all through the shared unit sss_alu. Uses sss_pkg.
`default_nettype none
module sss_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire sss_pkg::item_type    item,
   input  wire sss_pkg::cfg_type     cfg,
   input  wire logic                 out_free,
   output logic                      idle,
   output sss_pkg::emit_type         emit,
   output sss_pkg::alu_cmd_type      alu_cmd,
   input  wire sss_pkg::alu_rsp_type alu_rsp
);

   sss_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic [31:0] wp_x_ff, wp_x_in, wp_y_ff, wp_y_in;
   logic [47:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [sss_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [31:0] nb_x_ff, nb_x_in, nb_y_ff, nb_y_in;
   logic        fin_ff, fin_in;
   logic [48:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [47:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [62:0] acc_ff, acc_in;
   logic [31:0] len_ff, len_in;
   logic [30:0] qx_ff, qx_in;
   logic [30:0] lim_ff, lim_in;
   logic [31:0] seek_x_ff, seek_x_in, seek_y_ff, seek_y_in;
   logic [31:0] sep_x_ff, sep_x_in, sep_y_ff, sep_y_in;

   logic [32:0] dx, dy, adx, ady;
   logic [48:0] mvx, mvy, sx, sy, nvx49, npx49, npy49;
   logic [47:0] mx;
   logic [31:0] nvx, nvy;

   function automatic logic [48:0] mag49(input logic [48:0] v);
      return v[48] ? (49'd0 - v) : v;
   endfunction

   function automatic logic [32:0] mag33(input logic [32:0] v);
      return v[32] ? (33'd0 - v) : v;
   endfunction

   function automatic logic [31:0] sat32(input logic [48:0] v);
      if (!v[48] && (|v[47:31])) return 32'h7FFF_FFFF;
      if (v[48] && !(&v[47:31])) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [47:0] sat48(input logic [48:0] v);
      if (v[48:47] == 2'b01) return 48'h7FFF_FFFF_FFFF;
      if (v[48:47] == 2'b10) return 48'h8000_0000_0000;
      return v[47:0];
   endfunction

   function automatic logic [48:0] sext32(input logic [31:0] v);
      return {{17{v[31]}}, v};
   endfunction

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      vel_x_in  = vel_x_ff;
      vel_y_in  = vel_y_ff;
      wp_x_in   = wp_x_ff;
      wp_y_in   = wp_y_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      cnt_in    = cnt_ff;
      nb_x_in   = nb_x_ff;
      nb_y_in   = nb_y_ff;
      fin_in    = fin_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      qx_in     = qx_ff;
      lim_in    = lim_ff;
      seek_x_in = seek_x_ff;
      seek_y_in = seek_y_ff;
      sep_x_in  = sep_x_ff;
      sep_y_in  = sep_y_ff;

      alu_cmd.op    = sss_pkg::ALU_NONE;
      alu_cmd.opa   = '0;
      alu_cmd.opb   = '0;
      alu_cmd.steps = '0;

      dx   = {pos_x_ff[31], pos_x_ff} - {nb_x_ff[31], nb_x_ff};
      dy   = {pos_y_ff[31], pos_y_ff} - {nb_y_ff[31], nb_y_ff};
      adx  = mag33(dx);
      ady  = mag33(dy);
      mvx  = mag49(vx_ff);
      mvy  = mag49(vy_ff);
      mx   = (ax_ff > ay_ff) ? ax_ff : ay_ff;
      sx   = sext32(sum_x_ff[47:0] == 48'd0 ? 32'd0 : 32'd0);
      sy   = sx;
      nvx  = sat32(vx_ff);
      nvy  = sat32(vy_ff);
      nvx49 = sext32(nvx);
      npx49 = sext32(pos_x_ff) + nvx49;
      npy49 = sext32(pos_y_ff) + sext32(nvy);

      emit.valid       = 1'b0;
      emit.new_vel_x   = nvx;
      emit.new_vel_y   = nvy;
      emit.new_pos_x   = sat32(npx49);
      emit.new_pos_y   = sat32(npy49);
      emit.close_count = cnt_ff;

      case (state_ff)
         sss_pkg::ST_IDLE: begin
            if (start) begin
               fin_in = item.final_item;
               if (item.opcode == sss_pkg::OP_LOAD) begin
                  pos_x_in = item.pos_x;
                  pos_y_in = item.pos_y;
                  vel_x_in = item.vel_x;
                  vel_y_in = item.vel_y;
                  wp_x_in  = item.target_x;
                  wp_y_in  = item.target_y;
                  sum_x_in = '0;
                  sum_y_in = '0;
                  cnt_in   = '0;
                  if (item.final_item) state_in = sss_pkg::ST_EM_SEEK;
               end else begin
                  nb_x_in  = item.pos_x;
                  nb_y_in  = item.pos_y;
                  state_in = sss_pkg::ST_NB_CHK;
               end
            end
         end

         sss_pkg::ST_NB_CHK: begin
            vx_in = {{16{dx[32]}}, dx};
            vy_in = {{16{dy[32]}}, dy};
            ax_in = 48'(adx);
            ay_in = 48'(ady);
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(adx[30:0]);
            alu_cmd.opb = 63'(adx[30:0]);
            if (cnt_ff >= sss_pkg::NB_CAP ||
                adx >= {2'b00, cfg.separation_radius} ||
                ady >= {2'b00, cfg.separation_radius}) begin
               state_in = sss_pkg::ST_NB_END;
            end else begin
               state_in = sss_pkg::ST_NB_SQ1;
            end
         end

         sss_pkg::ST_NB_SQ1: begin
            acc_in      = 63'(alu_rsp.prod);
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(ay_ff[30:0]);
            alu_cmd.opb = 63'(ay_ff[30:0]);
            state_in    = sss_pkg::ST_NB_SQ2;
         end

         sss_pkg::ST_NB_SQ2: begin
            acc_in      = acc_ff + 63'(alu_rsp.prod);
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(cfg.separation_radius);
            alu_cmd.opb = 63'(cfg.separation_radius);
            state_in    = sss_pkg::ST_NB_CMP;
         end

         sss_pkg::ST_NB_CMP: begin
            if (acc_ff == 63'd0 || acc_ff >= 63'(alu_rsp.prod)) begin
               state_in = sss_pkg::ST_NB_END;
            end else begin
               state_in = sss_pkg::ST_NB_DX;
            end
         end

         sss_pkg::ST_NB_DX: begin
            alu_cmd.op    = sss_pkg::ALU_DIV;
            alu_cmd.opa   = {ax_ff[31:0], 32'd0} + 64'(acc_ff[62:1]);
            alu_cmd.opb   = acc_ff;
            alu_cmd.steps = sss_pkg::DIV_STEPS_PUSH;
            state_in      = sss_pkg::ST_NB_DXW;
         end

         sss_pkg::ST_NB_DXW: begin
            if (alu_rsp.done) begin
               sum_x_in = sat48({sum_x_ff[47], sum_x_ff} + (vx_ff[48] ?
                          (49'd0 - 49'(alu_rsp.quot)) : 49'(alu_rsp.quot)));
               alu_cmd.op    = sss_pkg::ALU_DIV;
               alu_cmd.opa   = {ay_ff[31:0], 32'd0} + 64'(acc_ff[62:1]);
               alu_cmd.opb   = acc_ff;
               alu_cmd.steps = sss_pkg::DIV_STEPS_PUSH;
               state_in      = sss_pkg::ST_NB_DYW;
            end
         end

         sss_pkg::ST_NB_DYW: begin
            if (alu_rsp.done) begin
               sum_y_in = sat48({sum_y_ff[47], sum_y_ff} + (vy_ff[48] ?
                          (49'd0 - 49'(alu_rsp.quot)) : 49'(alu_rsp.quot)));
               cnt_in   = cnt_ff + 1'b1;
               state_in = sss_pkg::ST_NB_END;
            end
         end

         sss_pkg::ST_NB_END: begin
            state_in = fin_ff ? sss_pkg::ST_EM_SEEK : sss_pkg::ST_IDLE;
         end

         sss_pkg::ST_EM_SEEK: begin
            if (pos_x_ff != wp_x_ff || pos_y_ff != wp_y_ff) begin
               vx_in    = sext32(wp_x_ff) - sext32(pos_x_ff);
               vy_in    = sext32(wp_y_ff) - sext32(pos_y_ff);
               lim_in   = cfg.max_speed;
               ret_in   = sss_pkg::ST_EM_SEEK_CL;
               state_in = sss_pkg::ST_SC0;
            end else begin
               seek_x_in = '0;
               seek_y_in = '0;
               state_in  = sss_pkg::ST_EM_SEP;
            end
         end

         sss_pkg::ST_EM_SEEK_CL: begin
            vx_in    = vx_ff - sext32(vel_x_ff);
            vy_in    = vy_ff - sext32(vel_y_ff);
            lim_in   = cfg.max_steer_force;
            ret_in   = sss_pkg::ST_EM_SEEK_DONE;
            state_in = sss_pkg::ST_CL0;
         end

         sss_pkg::ST_EM_SEEK_DONE: begin
            seek_x_in = vx_ff[31:0];
            seek_y_in = vy_ff[31:0];
            state_in  = sss_pkg::ST_EM_SEP;
         end

         sss_pkg::ST_EM_SEP: begin
            if (sum_x_ff != 48'd0 || sum_y_ff != 48'd0) begin
               vx_in    = {sum_x_ff[47], sum_x_ff};
               vy_in    = {sum_y_ff[47], sum_y_ff};
               lim_in   = cfg.max_speed;
               ret_in   = sss_pkg::ST_EM_SEP_CL;
               state_in = sss_pkg::ST_SC0;
            end else begin
               sep_x_in = sx[31:0];
               sep_y_in = sy[31:0];
               state_in = sss_pkg::ST_EM_VEL;
            end
         end

         sss_pkg::ST_EM_SEP_CL: begin
            vx_in    = vx_ff - sext32(vel_x_ff);
            vy_in    = vy_ff - sext32(vel_y_ff);
            lim_in   = cfg.max_separation_force;
            ret_in   = sss_pkg::ST_EM_SEP_DONE;
            state_in = sss_pkg::ST_CL0;
         end

         sss_pkg::ST_EM_SEP_DONE: begin
            sep_x_in = vx_ff[31:0];
            sep_y_in = vy_ff[31:0];
            state_in = sss_pkg::ST_EM_VEL;
         end

         sss_pkg::ST_EM_VEL: begin
            vx_in    = sext32(vel_x_ff) + sext32(seek_x_ff) + sext32(sep_x_ff);
            vy_in    = sext32(vel_y_ff) + sext32(seek_y_ff) + sext32(sep_y_ff);
            lim_in   = cfg.max_speed;
            ret_in   = sss_pkg::ST_EM_OUT;
            state_in = sss_pkg::ST_CL0;
         end

         sss_pkg::ST_EM_OUT: begin
            emit.valid = 1'b1;
            if (out_free) begin
               pos_x_in = emit.new_pos_x;
               pos_y_in = emit.new_pos_y;
               vel_x_in = nvx;
               vel_y_in = nvy;
               sum_x_in = '0;
               sum_y_in = '0;
               cnt_in   = '0;
               state_in = sss_pkg::ST_IDLE;
            end
         end

         sss_pkg::ST_CL0: begin
            ax_in       = mvx[47:0];
            ay_in       = mvy[47:0];
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(mvx[30:0]);
            alu_cmd.opb = 63'(mvx[30:0]);
            if (mvx > 49'(lim_ff) || mvy > 49'(lim_ff)) begin
               state_in = sss_pkg::ST_SC0;
            end else begin
               state_in = sss_pkg::ST_CL1;
            end
         end

         sss_pkg::ST_CL1: begin
            acc_in      = 63'(alu_rsp.prod);
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(ay_ff[30:0]);
            alu_cmd.opb = 63'(ay_ff[30:0]);
            state_in    = sss_pkg::ST_CL2;
         end

         sss_pkg::ST_CL2: begin
            acc_in      = acc_ff + 63'(alu_rsp.prod);
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(lim_ff);
            alu_cmd.opb = 63'(lim_ff);
            state_in    = sss_pkg::ST_CL3;
         end

         sss_pkg::ST_CL3: begin
            state_in = (acc_ff > 63'(alu_rsp.prod)) ? sss_pkg::ST_SC0 : ret_ff;
         end

         sss_pkg::ST_SC0: begin
            ax_in = mvx[47:0];
            ay_in = mvy[47:0];
            if (mvx == 49'd0 && mvy == 49'd0) begin
               vx_in    = '0;
               vy_in    = '0;
               state_in = ret_ff;
            end else begin
               state_in = sss_pkg::ST_SCN;
            end
         end

         sss_pkg::ST_SCN: begin
            if (|mx[47:31]) begin
               ax_in = {1'b0, ax_ff[47:1]};
               ay_in = {1'b0, ay_ff[47:1]};
            end else if (!mx[30]) begin
               ax_in = {ax_ff[46:0], 1'b0};
               ay_in = {ay_ff[46:0], 1'b0};
            end else begin
               state_in = sss_pkg::ST_SC_SQ0;
            end
         end

         sss_pkg::ST_SC_SQ0: begin
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(ax_ff[30:0]);
            alu_cmd.opb = 63'(ax_ff[30:0]);
            state_in    = sss_pkg::ST_SC_SQ1;
         end

         sss_pkg::ST_SC_SQ1: begin
            acc_in      = 63'(alu_rsp.prod);
            alu_cmd.op  = sss_pkg::ALU_MUL;
            alu_cmd.opa = 64'(ay_ff[30:0]);
            alu_cmd.opb = 63'(ay_ff[30:0]);
            state_in    = sss_pkg::ST_SC_SQ2;
         end

         sss_pkg::ST_SC_SQ2: begin
            acc_in   = acc_ff + 63'(alu_rsp.prod);
            state_in = sss_pkg::ST_SC_RT;
         end

         sss_pkg::ST_SC_RT: begin
            alu_cmd.op  = sss_pkg::ALU_SQRT;
            alu_cmd.opa = 64'(acc_ff);
            state_in    = sss_pkg::ST_SC_RTW;
         end

         sss_pkg::ST_SC_RTW: begin
            if (alu_rsp.done) begin
               len_in      = alu_rsp.quot[31:0];
               alu_cmd.op  = sss_pkg::ALU_MUL;
               alu_cmd.opa = 64'(ax_ff[30:0]);
               alu_cmd.opb = 63'(lim_ff);
               state_in    = sss_pkg::ST_SC_DX;
            end
         end

         sss_pkg::ST_SC_DX: begin
            alu_cmd.op    = sss_pkg::ALU_DIV;
            alu_cmd.opa   = 64'(alu_rsp.prod) + 64'(len_ff[31:1]);
            alu_cmd.opb   = 63'(len_ff);
            alu_cmd.steps = sss_pkg::DIV_STEPS_SCALE;
            state_in      = sss_pkg::ST_SC_DXW;
         end

         sss_pkg::ST_SC_DXW: begin
            if (alu_rsp.done) begin
               qx_in       = alu_rsp.quot[30:0];
               alu_cmd.op  = sss_pkg::ALU_MUL;
               alu_cmd.opa = 64'(ay_ff[30:0]);
               alu_cmd.opb = 63'(lim_ff);
               state_in    = sss_pkg::ST_SC_DY;
            end
         end

         sss_pkg::ST_SC_DY: begin
            alu_cmd.op    = sss_pkg::ALU_DIV;
            alu_cmd.opa   = 64'(alu_rsp.prod) + 64'(len_ff[31:1]);
            alu_cmd.opb   = 63'(len_ff);
            alu_cmd.steps = sss_pkg::DIV_STEPS_SCALE;
            state_in      = sss_pkg::ST_SC_DYW;
         end

         sss_pkg::ST_SC_DYW: begin
            if (alu_rsp.done) begin
               vx_in = vx_ff[48] ? (49'd0 - 49'(qx_ff)) : 49'(qx_ff);
               vy_in = vy_ff[48] ? (49'd0 - 49'(alu_rsp.quot[30:0]))
                                 : 49'(alu_rsp.quot[30:0]);
               state_in = ret_ff;
            end
         end

         default: begin
            state_in = sss_pkg::ST_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == sss_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sss_pkg::ST_IDLE;
         ret_ff   <= sss_pkg::ST_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         wp_x_ff  <= '0;
         wp_y_ff  <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         wp_x_ff  <= wp_x_in;
         wp_y_ff  <= wp_y_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_x_ff   <= nb_x_in;
      nb_y_ff   <= nb_y_in;
      fin_ff    <= fin_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      acc_ff    <= acc_in;
      len_ff    <= len_in;
      qx_ff     <= qx_in;
      lim_ff    <= lim_in;
      seek_x_ff <= seek_x_in;
      seek_y_ff <= seek_y_in;
      sep_x_ff  <= sep_x_in;
      sep_y_ff  <= sep_y_in;
   end

endmodule
`default_nettype wire

### hw/rtl/seek_separation_steering_step.sv
// Work: a plain load request leaves the unit idle; a neighbour request inside
// the radius runs two 34-step divides; a final request adds up to five vector
// scalings (normalise shift, 32-step root, two 31-step divides).
// Throughput: one request at a time, taken only while the sequencer is idle.
// Reset: synchronous; agent state clears, registers take defaults, no sweep.
// Top level: stream ports, control registers, result register. Uses sss_pkg,
// sss_seq and sss_alu.
`default_nettype none
module seek_separation_steering_step (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, vel_x, vel_y, target_x, target_y
   input  wire logic [191:0] req_tdata,
   // opcode
   input  wire logic [0:0]   req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // new_vel_x, new_vel_y, new_pos_x, new_pos_y, close_count, zero pad
   output logic [143:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [30:0]  csr_data
);

   sss_pkg::cfg_type      cfg_ff, cfg_in;
   sss_pkg::item_type     item;
   sss_pkg::emit_type     emit;
   sss_pkg::alu_cmd_type  alu_cmd;
   sss_pkg::alu_rsp_type  alu_rsp;
   logic                  idle, start, out_free;
   logic                  valid_ff, valid_in;
   logic [143:0]          data_ff, data_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (sss_pkg::csr_index_type'(csr_index))
            sss_pkg::CSR_MAX_SPEED:  cfg_in.max_speed            = csr_data;
            sss_pkg::CSR_MAX_STEER:  cfg_in.max_steer_force      = csr_data;
            sss_pkg::CSR_MAX_SEP:    cfg_in.max_separation_force = csr_data;
            sss_pkg::CSR_SEP_RADIUS: cfg_in.separation_radius    = csr_data;
            default: begin
            end
         endcase
      end
   end

   assign item.opcode     = sss_pkg::op_type'(req_tuser[0]);
   assign item.pos_x      = req_tdata[31:0];
   assign item.pos_y      = req_tdata[63:32];
   assign item.vel_x      = req_tdata[95:64];
   assign item.vel_y      = req_tdata[127:96];
   assign item.target_x   = req_tdata[159:128];
   assign item.target_y   = req_tdata[191:160];
   assign item.final_item = req_tlast;

   assign req_tready = idle;
   assign start      = req_tvalid & idle;
   assign out_free   = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff & ~rsp_tready;
      data_in  = data_ff;
      if (emit.valid && out_free) begin
         valid_in = 1'b1;
         data_in  = {7'd0, emit.close_count, emit.new_pos_y, emit.new_pos_x,
                     emit.new_vel_y, emit.new_vel_x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed            <= sss_pkg::RST_MAX_SPEED;
         cfg_ff.max_steer_force      <= sss_pkg::RST_MAX_STEER;
         cfg_ff.max_separation_force <= sss_pkg::RST_MAX_SEP;
         cfg_ff.separation_radius    <= sss_pkg::RST_SEP_RADIUS;
         valid_ff                    <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   sss_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .idle     (idle),
      .emit     (emit),
      .alu_cmd  (alu_cmd),
      .alu_rsp  (alu_rsp)
   );

   sss_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

endmodule
`default_nettype wire

### hw/rtl/sss_check.sv
// Port-level checks for seek_separation_steering_step, bound to the top.
// Depends on sss_pkg for the opcode codes.
`default_nettype none
module sss_check (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [191:0] req_tdata,
   input wire logic [0:0]   req_tuser,
   input wire logic         req_tlast,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [143:0] rsp_tdata,
   input wire logic         csr_valid,
   input wire logic         csr_ready,
   input wire logic [1:0]   csr_index,
   input wire logic [30:0]  csr_data
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_nb_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == sss_pkg::OP_NEIGHBOUR
      |=> !req_tready)
      else $error("neighbour request did not occupy the unit");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == sss_pkg::OP_LOAD && !req_tlast
      |=> req_tready)
      else $error("plain load request stalled the input");

   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("final request did not start a result");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without preceding work");

endmodule

bind seek_separation_steering_step sss_check u_sss_check (.*);
`default_nettype wire
